// ----- rtl/quaternion_rotate_vector_assert.svh -----
// Assertion macros for the quaternion vector rotation block.
// Depends on nothing; included by the top level.
`ifndef QUATERNION_ROTATE_VECTOR_ASSERT_SVH
`define QUATERNION_ROTATE_VECTOR_ASSERT_SVH
`ifndef SYNTH
`define QRV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define QRV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define QRV_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define QRV_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/qrv_pkg.sv -----
// Types, widths and rounding helper of the quaternion vector rotation block.
// Depends on nothing.
package qrv_pkg;

	localparam int FRAC_BITS = 14;
	localparam int SQ_STEPS  = 30;
	localparam int ROOT_W    = 30;
	localparam int REM_W     = 34;
	localparam int DIV_STEPS = 16;
	localparam int DVD_W     = 44;
	localparam int DREM_W    = 30;
	localparam int T_W       = 35;
	localparam int R_W       = 53;
	localparam int OUT_MAX   = 32767;
	localparam int OUT_MIN   = -32768;
	localparam int QUO_MAX   = 16384;

	typedef struct packed {
		logic signed [15:0] w;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} quat_t;

	typedef struct packed {
		quat_t              q;
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [15:0] vz;
	} item_t;

	function automatic logic signed [15:0] round_sat(input logic signed [R_W-1:0] r);
		logic [R_W:0]                       rs;
		logic signed [R_W-2*FRAC_BITS:0]    qv;
		rs = {r[R_W-1], r} + (R_W+1)'(1 << (2*FRAC_BITS-1));
		qv = rs[R_W:2*FRAC_BITS];
		if (qv > OUT_MAX)
			return 16'sh7fff;
		else if (qv < OUT_MIN)
			return 16'sh8000;
		else
			return 16'(qv);
	endfunction

endpackage

// ----- rtl/quaternion_rotate_vector.sv -----
// Quaternion vector rotation: normalise a vector, rotate it by q, round and saturate.
// Depends on qrv_pkg and quaternion_rotate_vector_assert.svh.
//
// Usage: one request channel (in_valid/in_ready) carries a quaternion in Q2.14
// and a 16-bit vector; one result channel (out_valid/out_ready) returns the
// rotated unit vector in Q2.14, saturated. A zero vector returns zero.
// Throughput: one request per cycle while the receiver takes results; every
// stage is a register stage, down to each one-bit square-root and divide step.
// Stages: squares, sum, 30 root steps, dividend set-up, 16 divide steps,
// n*conj(q) products, sums, q*t products, sums, round and saturate.
// The whole pipe advances together; when the receiver stalls with a result
// waiting, every stage holds and in_ready drops, so nothing is lost or repeated.
// Reset clears all valid bits; the pipe is empty and ready after reset.
// No state is kept between requests.
`include "quaternion_rotate_vector_assert.svh"
module quaternion_rotate_vector import qrv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] vec_x,
	input  logic signed [15:0] vec_y,
	input  logic signed [15:0] vec_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] rot_x,
	output logic signed [15:0] rot_y,
	output logic signed [15:0] rot_z
);

	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// squares
	logic               vld_s1;
	item_t              item_s1;
	logic [30:0]        sqx_s1, sqy_s1, sqz_s1;
	logic signed [31:0] sqx, sqy, sqz;
	assign sqx = vec_x * vec_x;
	assign sqy = vec_y * vec_y;
	assign sqz = vec_z * vec_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (adv)
			vld_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= '{q: '{w: quat_w, x: quat_x, y: quat_y, z: quat_z},
				vx: vec_x, vy: vec_y, vz: vec_z};
			sqx_s1 <= sqx[30:0];
			sqy_s1 <= sqy[30:0];
			sqz_s1 <= sqz[30:0];
		end
	end

	// sum of squares
	logic        vld_s2;
	item_t       item_s2;
	logic [31:0] sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (adv)
			vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2 <= item_s1;
			sum_s2  <= {1'b0, sqx_s1} + {1'b0, sqy_s1} + {1'b0, sqz_s1};
		end
	end

	// square root, one bit per stage
	logic              sq_vld_s  [SQ_STEPS];
	item_t             sq_item_s [SQ_STEPS];
	logic [31:0]       sq_sum_s  [SQ_STEPS];
	logic [REM_W-1:0]  sq_rem_s  [SQ_STEPS];
	logic [ROOT_W-1:0] sq_root_s [SQ_STEPS];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		logic              pv;
		item_t             pit;
		logic [31:0]       ps;
		logic [REM_W-1:0]  prem;
		logic [ROOT_W-1:0] proot;
		logic [59:0]       rad;
		logic [1:0]        pair;
		logic [REM_W-1:0]  rsh, trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign pv    = vld_s2;
			assign pit   = item_s2;
			assign ps    = sum_s2;
			assign prem  = '0;
			assign proot = '0;
		end else begin : g_next
			assign pv    = sq_vld_s[k-1];
			assign pit   = sq_item_s[k-1];
			assign ps    = sq_sum_s[k-1];
			assign prem  = sq_rem_s[k-1];
			assign proot = sq_root_s[k-1];
		end

		assign rad   = {ps, 28'd0};
		assign pair  = rad[2*(SQ_STEPS-1-k) +: 2];
		assign rsh   = {prem[REM_W-3:0], pair};
		assign trial = {{(REM_W-ROOT_W-2){1'b0}}, proot, 2'b01};
		assign ge    = rsh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_vld_s[k] <= 1'b0;
			else if (adv)
				sq_vld_s[k] <= pv;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_item_s[k] <= pit;
				sq_sum_s[k]  <= ps;
				sq_rem_s[k]  <= ge ? rsh - trial : rsh;
				sq_root_s[k] <= {proot[ROOT_W-2:0], ge};
			end
		end
	end

	// dividend set-up
	logic              vld_s33;
	quat_t             quat_s33;
	logic              zero_s33;
	logic [ROOT_W-1:0] m_s33;
	logic [2:0]        neg_s33;
	logic [DVD_W-1:0]  dvd_s33 [3];
	item_t             sq_last;
	logic [ROOT_W-1:0] m_last;
	logic signed [15:0] vin [3];
	logic [15:0]       vabs [3];

	assign sq_last = sq_item_s[SQ_STEPS-1];
	assign m_last  = sq_root_s[SQ_STEPS-1];

	always_comb begin
		vin[0] = sq_last.vx;
		vin[1] = sq_last.vy;
		vin[2] = sq_last.vz;
		for (int l = 0; l < 3; l++)
			vabs[l] = vin[l][15] ? 16'(-vin[l]) : 16'(vin[l]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s33 <= 1'b0;
		else if (adv)
			vld_s33 <= sq_vld_s[SQ_STEPS-1];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			quat_s33 <= sq_last.q;
			zero_s33 <= sq_sum_s[SQ_STEPS-1] == 32'd0;
			m_s33    <= m_last;
			for (int l = 0; l < 3; l++) begin
				neg_s33[l] <= vin[l][15];
				dvd_s33[l] <= {vabs[l], 28'd0} + {15'd0, m_last[ROOT_W-1:1]};
			end
		end
	end

	// restoring divide, one quotient bit per stage, three lanes
	logic              dv_vld_s  [DIV_STEPS];
	quat_t             dv_quat_s [DIV_STEPS];
	logic              dv_zero_s [DIV_STEPS];
	logic [ROOT_W-1:0] dv_m_s    [DIV_STEPS];
	logic [2:0]        dv_neg_s  [DIV_STEPS];
	logic [DREM_W-1:0] dv_rem_s  [DIV_STEPS][3];
	logic [15:0]       dv_lo_s   [DIV_STEPS][3];
	logic [15:0]       dv_quo_s  [DIV_STEPS][3];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic              pv;
		quat_t             pq;
		logic              pz;
		logic [ROOT_W-1:0] pm;
		logic [2:0]        pn;

		if (k == 0) begin : g_first
			assign pv = vld_s33;
			assign pq = quat_s33;
			assign pz = zero_s33;
			assign pm = m_s33;
			assign pn = neg_s33;
		end else begin : g_next
			assign pv = dv_vld_s[k-1];
			assign pq = dv_quat_s[k-1];
			assign pz = dv_zero_s[k-1];
			assign pm = dv_m_s[k-1];
			assign pn = dv_neg_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_vld_s[k] <= 1'b0;
			else if (adv)
				dv_vld_s[k] <= pv;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_quat_s[k] <= pq;
				dv_zero_s[k] <= pz;
				dv_m_s[k]    <= pm;
				dv_neg_s[k]  <= pn;
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [DREM_W-1:0] prem;
			logic [15:0]       plo, pquo;
			logic [DREM_W:0]   rsh;
			logic              ge;

			if (k == 0) begin : g_first
				assign prem = {2'b00, dvd_s33[l][DVD_W-1:16]};
				assign plo  = dvd_s33[l][15:0];
				assign pquo = '0;
			end else begin : g_next
				assign prem = dv_rem_s[k-1][l];
				assign plo  = dv_lo_s[k-1][l];
				assign pquo = dv_quo_s[k-1][l];
			end

			assign rsh = {prem, plo[15]};
			assign ge  = rsh >= {1'b0, pm};

			always_ff @(posedge clk) begin
				if (adv) begin
					dv_rem_s[k][l] <= ge ? DREM_W'(rsh - {1'b0, pm}) : rsh[DREM_W-1:0];
					dv_lo_s[k][l]  <= {plo[14:0], 1'b0};
					dv_quo_s[k][l] <= {pquo[14:0], ge};
				end
			end
		end
	end

	// n * conj(q) partial products
	localparam int DL = DIV_STEPS - 1;
	logic               vld_s50;
	quat_t              quat_s50;
	logic               zero_s50;
	logic signed [32:0] np_s50 [3][4];
	logic signed [16:0] nv [3];
	logic signed [15:0] qd [4];

	always_comb begin
		qd[0] = dv_quat_s[DL].w;
		qd[1] = dv_quat_s[DL].x;
		qd[2] = dv_quat_s[DL].y;
		qd[3] = dv_quat_s[DL].z;
		for (int l = 0; l < 3; l++)
			nv[l] = dv_neg_s[DL][l] ? -$signed({1'b0, dv_quo_s[DL][l]})
				: $signed({1'b0, dv_quo_s[DL][l]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s50 <= 1'b0;
		else if (adv)
			vld_s50 <= dv_vld_s[DL];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			quat_s50 <= dv_quat_s[DL];
			zero_s50 <= dv_zero_s[DL];
			for (int l = 0; l < 3; l++)
				for (int j = 0; j < 4; j++)
					np_s50[l][j] <= nv[l] * qd[j];
		end
	end

	// t = n * conj(q)
	logic                 vld_s51;
	quat_t                quat_s51;
	logic                 zero_s51;
	logic signed [T_W-1:0] t_s51 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s51 <= 1'b0;
		else if (adv)
			vld_s51 <= vld_s50;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			quat_s51 <= quat_s50;
			zero_s51 <= zero_s50;
			t_s51[0] <= T_W'(np_s50[0][1]) + T_W'(np_s50[1][2]) + T_W'(np_s50[2][3]);
			t_s51[1] <= T_W'(np_s50[0][0]) - T_W'(np_s50[1][3]) + T_W'(np_s50[2][2]);
			t_s51[2] <= T_W'(np_s50[1][0]) - T_W'(np_s50[2][1]) + T_W'(np_s50[0][3]);
			t_s51[3] <= T_W'(np_s50[2][0]) - T_W'(np_s50[0][2]) + T_W'(np_s50[1][1]);
		end
	end

	// q * t partial products
	logic               vld_s52;
	logic               zero_s52;
	logic signed [50:0] rp_s52 [4][4];
	logic signed [15:0] qt [4];

	always_comb begin
		qt[0] = quat_s51.w;
		qt[1] = quat_s51.x;
		qt[2] = quat_s51.y;
		qt[3] = quat_s51.z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s52 <= 1'b0;
		else if (adv)
			vld_s52 <= vld_s51;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s52 <= zero_s51;
			for (int k = 0; k < 4; k++)
				for (int j = 0; j < 4; j++)
					rp_s52[k][j] <= t_s51[k] * qt[j];
		end
	end

	// r = q * t, vector part
	logic                  vld_s53;
	logic                  zero_s53;
	logic signed [R_W-1:0] r_s53 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s53 <= 1'b0;
		else if (adv)
			vld_s53 <= vld_s52;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s53 <= zero_s52;
			r_s53[0] <= R_W'(rp_s52[1][0]) + R_W'(rp_s52[0][1]) + R_W'(rp_s52[3][2])
				- R_W'(rp_s52[2][3]);
			r_s53[1] <= R_W'(rp_s52[2][0]) + R_W'(rp_s52[0][2]) + R_W'(rp_s52[1][3])
				- R_W'(rp_s52[3][1]);
			r_s53[2] <= R_W'(rp_s52[3][0]) + R_W'(rp_s52[0][3]) + R_W'(rp_s52[2][1])
				- R_W'(rp_s52[1][2]);
		end
	end

	// round, saturate, hold for the receiver
	logic               vld_s54;
	logic signed [15:0] rot_x_s54, rot_y_s54, rot_z_s54;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s54 <= 1'b0;
		else if (adv)
			vld_s54 <= vld_s53;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			rot_x_s54 <= zero_s53 ? 16'sd0 : round_sat(r_s53[0]);
			rot_y_s54 <= zero_s53 ? 16'sd0 : round_sat(r_s53[1]);
			rot_z_s54 <= zero_s53 ? 16'sd0 : round_sat(r_s53[2]);
		end
	end

	assign out_valid = vld_s54;
	assign rot_x     = rot_x_s54;
	assign rot_y     = rot_y_s54;
	assign rot_z     = rot_z_s54;

	`QRV_ASSERT_IMP(a_root_range, clk, arst_n,
		sq_vld_s[SQ_STEPS-1] && sq_sum_s[SQ_STEPS-1] != 32'd0,
		sq_root_s[SQ_STEPS-1][ROOT_W-1:FRAC_BITS] != '0)
	`QRV_ASSERT_IMP(a_quo_range, clk, arst_n,
		dv_vld_s[DL] && !dv_zero_s[DL],
		dv_quo_s[DL][0] <= 16'(QUO_MAX) && dv_quo_s[DL][1] <= 16'(QUO_MAX)
		&& dv_quo_s[DL][2] <= 16'(QUO_MAX))
	`QRV_ASSERT_NXT(a_last_moves, clk, arst_n, vld_s53 && adv, out_valid)

endmodule

// ----- verif/quaternion_rotate_vector_tb.sv -----
// Testbench for quaternion_rotate_vector: random and directed requests, scoreboard check.
// Depends on qrv_pkg and the quaternion_rotate_vector RTL.
`timescale 1ns / 100ps
module quaternion_rotate_vector_tb;
	import qrv_pkg::*;

	typedef struct {
		logic signed [15:0] w, x, y, z, vx, vy, vz;
	} rot_req_t;

	typedef struct {
		logic signed [15:0] x, y, z;
	} rot_vec_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [15:0] quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z;
	logic signed [15:0] rot_x, rot_y, rot_z;

	rot_req_t pending_reqs[$];
	rot_vec_t expected_rots[$];
	int errors = 0;
	bit stim_done = 0;
	bit calm = 0;
	bit sender_hold = 0;
	bit recv_hold = 0;
	int send_gap = 0;
	int recv_gap = 0;

	quaternion_rotate_vector i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] num);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > num) bitv >>= 2;
		while (bitv != 0) begin
			if (num >= res + bitv) begin
				num -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [15:0] round_clamp(input longint v);
		longint t, q;
		t = v + (64'sd1 <<< 27);
		q = t >>> 28;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return 16'(q);
	endfunction

	function automatic rot_vec_t rotate_vector(input rot_req_t r);
		longint q[4], c[4], p[4], t[4], o[4], v[3];
		longint a, n;
		logic [63:0] s, m;
		rot_vec_t res;
		q[0] = longint'(r.w); q[1] = longint'(r.x); q[2] = longint'(r.y);
		q[3] = longint'(r.z);
		v[0] = longint'(r.vx); v[1] = longint'(r.vy); v[2] = longint'(r.vz);
		s = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
		if (s == 0) begin
			res.x = '0; res.y = '0; res.z = '0;
			return res;
		end
		m = int_sqrt(s << 28);
		p[0] = 0;
		for (int i = 0; i < 3; i++) begin
			a = (v[i] < 0 ? -v[i] : v[i]) <<< 28;
			n = (a + longint'(m >> 1)) / longint'(m);
			p[1+i] = v[i] < 0 ? -n : n;
		end
		c[0] = q[0]; c[1] = -q[1]; c[2] = -q[2]; c[3] = -q[3];
		t[0] = p[0]*c[0] - p[1]*c[1] - p[2]*c[2] - p[3]*c[3];
		t[1] = p[0]*c[1] + p[1]*c[0] + p[2]*c[3] - p[3]*c[2];
		t[2] = p[0]*c[2] + p[2]*c[0] + p[3]*c[1] - p[1]*c[3];
		t[3] = p[0]*c[3] + p[3]*c[0] + p[1]*c[2] - p[2]*c[1];
		o[1] = q[0]*t[1] + q[1]*t[0] + q[2]*t[3] - q[3]*t[2];
		o[2] = q[0]*t[2] + q[2]*t[0] + q[3]*t[1] - q[1]*t[3];
		o[3] = q[0]*t[3] + q[3]*t[0] + q[1]*t[2] - q[2]*t[1];
		res.x = round_clamp(o[1]);
		res.y = round_clamp(o[2]);
		res.z = round_clamp(o[3]);
		return res;
	endfunction

	function automatic rot_req_t make_req(input int w, x, y, z, vx, vy, vz);
		rot_req_t r;
		r.w = 16'(w); r.x = 16'(x); r.y = 16'(y); r.z = 16'(z);
		r.vx = 16'(vx); r.vy = 16'(vy); r.vz = 16'(vz);
		return r;
	endfunction

	function automatic logic signed [15:0] rand_field(input int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 32767) - 16384);
			default: return 16'($urandom_range(0, 2)) * 16'sd16384 - 16'sd16384;
		endcase
	endfunction

	// random unit quaternion, mostly; some raw noise
	function automatic rot_req_t rand_req();
		rot_req_t r;
		real a, b, c, d, len;
		if ($urandom_range(0, 9) < 7) begin
			a = $urandom_range(0, 2000) - 1000.0;
			b = $urandom_range(0, 2000) - 1000.0;
			c = $urandom_range(0, 2000) - 1000.0;
			d = $urandom_range(0, 2000) - 1000.0;
			len = $sqrt(a*a + b*b + c*c + d*d);
			if (len < 1.0) begin
				a = 1000.0; len = 1000.0;
			end
			r.w = 16'($rtoi(a / len * 16384.0));
			r.x = 16'($rtoi(b / len * 16384.0));
			r.y = 16'($rtoi(c / len * 16384.0));
			r.z = 16'($rtoi(d / len * 16384.0));
		end else begin
			r.w = rand_field($urandom_range(0, 2));
			r.x = rand_field($urandom_range(0, 2));
			r.y = rand_field($urandom_range(0, 2));
			r.z = rand_field($urandom_range(0, 2));
		end
		case ($urandom_range(0, 3))
			0: begin
				r.vx = 16'($urandom_range(0, 20) - 10);
				r.vy = 16'($urandom_range(0, 20) - 10);
				r.vz = 16'($urandom_range(0, 20) - 10);
			end
			default: begin
				r.vx = 16'($urandom);
				r.vy = 16'($urandom);
				r.vz = 16'($urandom);
			end
		endcase
		return r;
	endfunction

	initial begin
		pending_reqs.push_back(make_req(16384, 0, 0, 0, 1, 0, 0));
		pending_reqs.push_back(make_req(16384, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(-32768, 0, 0, 0, 0, 7, 0));
		pending_reqs.push_back(make_req(0, 16384, 0, 0, 0, 1, 0));
		pending_reqs.push_back(make_req(0, 0, 16384, 0, 0, 0, -1));
		pending_reqs.push_back(make_req(11585, 0, 0, 11585, 5, 0, 0));
		pending_reqs.push_back(make_req(32767, 32767, 32767, 32767, 1, 1, 1));
		pending_reqs.push_back(make_req(-32768, -32768, -32768, -32768, -1, -1, -1));
		pending_reqs.push_back(make_req(32767, -32768, 32767, -32768, 32767, 0, 0));
		pending_reqs.push_back(make_req(8192, 8192, 8192, 8192, -32768, -32768, -32768));
		pending_reqs.push_back(make_req(16384, 0, 0, 0, 32767, 32767, 32767));
		pending_reqs.push_back(make_req(0, 0, 0, 0, 3, 4, 5));
		pending_reqs.push_back(make_req(-1, -1, -1, -1, -32768, 32767, -1));
		pending_reqs.push_back(make_req(9459, 9459, 9459, 9459, 1, 2, 2));
		pending_reqs.push_back(make_req(16384, 0, 0, 0, 0, 0, -32768));
		for (int i = 0; i < 950; i++) pending_reqs.push_back(rand_req());
	end

	initial begin
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
	end

	// sender pause until the pipe drains, once mid-run
	initial begin
		wait (arst_n);
		wait (pending_reqs.size() < 500);
		sender_hold = 1;
		wait (expected_rots.size() == 0);
		sender_hold = 0;
	end

	// long receiver hold-off so the pipe fills
	initial begin
		wait (arst_n);
		wait (pending_reqs.size() < 700);
		recv_hold = 1;
		repeat (200) @(posedge clk);
		recv_hold = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			{quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z} <= '0;
			send_gap <= 0;
			calm <= 0;
		end else begin
			if (pending_reqs.size() < 150) calm <= 1;
			if (!in_valid || in_ready) begin
				if (in_valid) expected_rots.push_back(rotate_vector(make_req(
					int'(quat_w), int'(quat_x), int'(quat_y), int'(quat_z),
					int'(vec_x), int'(vec_y), int'(vec_z))));
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 0;
				end else if (!calm && $urandom_range(0, 19) == 0) begin
					send_gap <= $urandom_range(1, 16);
					in_valid <= 0;
				end else if (sender_hold || pending_reqs.size() == 0) begin
					in_valid <= 0;
					if (pending_reqs.size() == 0 && !sender_hold) stim_done <= 1;
				end else begin
					rot_req_t r;
					r = pending_reqs.pop_front();
					in_valid <= 1;
					quat_w <= r.w; quat_x <= r.x; quat_y <= r.y; quat_z <= r.z;
					vec_x <= r.vx; vec_y <= r.vy; vec_z <= r.vz;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
			recv_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_rots.size() == 0) begin
					$display("%0t: unexpected result %0d %0d %0d", $time, rot_x, rot_y,
						rot_z);
					errors++;
				end else begin
					rot_vec_t e;
					e = expected_rots.pop_front();
					if (rot_x !== e.x) begin
						$display("%0t: rot_x expected %0d actual %0d", $time, e.x, rot_x);
						errors++;
					end
					if (rot_y !== e.y) begin
						$display("%0t: rot_y expected %0d actual %0d", $time, e.y, rot_y);
						errors++;
					end
					if (rot_z !== e.z) begin
						$display("%0t: rot_z expected %0d actual %0d", $time, e.z, rot_z);
						errors++;
					end
				end
			end
			if (recv_hold) begin
				out_ready <= 0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= 0;
			end else if (!calm && $urandom_range(0, 19) == 0) begin
				recv_gap <= $urandom_range(1, 16);
				out_ready <= 0;
			end else begin
				out_ready <= 1;
			end
		end
	end

	initial begin
		wait (stim_done);
		wait (expected_rots.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/qrv_pkg.sv
rtl/quaternion_rotate_vector.sv
verif/quaternion_rotate_vector_tb.sv
